FILE: rtl/rpas_pkg.sv
package rpas_pkg;

    localparam int MaxWidthDef  = 256;
    localparam int MaxHeightDef = 256;

    localparam logic [8:0]  NoHue       = 9'h1FF;
    localparam logic [23:0] SumMax      = 24'hFFFFFF;
    localparam logic [6:0]  EdgeSat     = 7'd127;

    localparam logic [2:0] CfgWidth   = 3'd0;
    localparam logic [2:0] CfgHeight  = 3'd1;
    localparam logic [2:0] CfgDivisor = 3'd2;
    localparam logic [2:0] CfgHueMin  = 3'd3;
    localparam logic [2:0] CfgFloor   = 3'd4;

    // request to the shared divider
    typedef struct packed {
        logic        start;
        logic [23:0] dividend;
        logic [16:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [23:0] quotient;
    } div_rsp_t;

endpackage

FILE: rtl/rpas_divider.sv
// Restoring divider, one quotient bit per cycle.
module rpas_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  rpas_pkg::div_req_t req,
    output rpas_pkg::div_rsp_t rsp
);

    logic [4:0]  count_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [23:0] quo_reg;
    logic [16:0] rem_reg;
    logic [16:0] dvs_reg;
    logic [17:0] trial;

    assign trial = {rem_reg, quo_reg[23]} - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= 5'd23;
            end
            else if (busy_reg)
            begin
                if (count_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                count_reg <= count_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[17])
            begin
                rem_reg <= trial[16:0];
                quo_reg <= {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[15:0], quo_reg[23]};
                quo_reg <= {quo_reg[22:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg) else $error("start lost");
    a_count_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("busy after done");

endmodule

FILE: rtl/rgb565_pixel_attribute_sobel_unit.sv
// Pixel attribute and Sobel unit. One request at a time: the block takes a
// pixel, computes luma, saturation, hue and a 3x3 Sobel edge strength from
// two line stores, and presents one result. A pixel with no hue quotient to
// work out passes through the read, calc and output states. A hue quotient
// or a frame mean costs one 24-step pass of the shared restoring divider
// between calc and output; a frame-end pixel that needs both makes two
// passes, hue first. Output stalls hold the result, and the next
// pixel is taken once the result has been collected. Line stores are
// undefined until written; edge is zero on the first two rows and columns.
module rgb565_pixel_attribute_sobel_unit
#(
    parameter int MAX_WIDTH  = rpas_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT = rpas_pkg::MaxHeightDef
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] pixel_word,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  luma,
    output logic [8:0]  hue_deg,
    output logic [5:0]  saturation,
    output logic [6:0]  edge_strength,
    output logic [29:0] attribute_word,
    output logic [7:0]  column,
    output logic [7:0]  line,
    output logic        frame_end,
    output logic [6:0]  mean_luma
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_CALC, S_HDIV, S_MDIV, S_OUT} state_t;

    state_t      state_reg;
    logic [8:0]  width_reg, height_reg;
    logic [16:0] divisor_reg;
    logic [5:0]  hmin_reg;
    logic [6:0]  floor_reg;

    logic [6:0]  older_mem [MAX_WIDTH];
    logic [6:0]  prev_mem  [MAX_WIDTH];
    logic [6:0]  older_rd_reg, prev_rd_reg;
    logic [6:0]  win_reg [6];
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [23:0] sum_reg;

    logic [15:0] px_reg;
    logic [6:0]  luma_reg;
    logic [8:0]  hue_reg;
    logic [5:0]  sat_reg;
    logic [6:0]  edge_reg;
    logic [7:0]  ocol_reg, orow_reg;
    logic        fend_reg;
    logic [6:0]  mean_reg;
    logic        hneg_reg;
    logic [8:0]  hbase_reg;

    // combinational pixel decode
    logic [4:0] r5, b5;
    logic [5:0] g6, r6, b6, mx, mn, dl;
    logic [6:0] lm;
    assign r5 = px_reg[7:3];
    assign g6 = {px_reg[2:0], px_reg[15:13]};
    assign b5 = px_reg[12:8];
    assign r6 = {r5, 1'b0};
    assign b6 = {b5, 1'b0};
    assign lm = 7'(({1'b0, r5, 2'b0} + {g6, 2'b0} + {2'b0, b5, 1'b0}
                    + {3'b0, g6}) >> 2);

    always_comb
    begin
        mx = r6;
        if (g6 > mx) mx = g6;
        if (b6 > mx) mx = b6;
        mn = r6;
        if (g6 < mn) mn = g6;
        if (b6 < mn) mn = b6;
        dl = mx - mn;
    end

    // hue numerator magnitude and sign
    logic [6:0]  hdiff;
    logic        hneg;
    logic [8:0]  hbase;
    logic [12:0] hnum;
    always_comb
    begin
        priority if (r6 == mx)
        begin
            hneg  = g6 < b6;
            hdiff = hneg ? 7'(b6 - g6) : 7'(g6 - b6);
            hbase = 9'd0;
        end
        else if (g6 == mx)
        begin
            hneg  = b6 < r6;
            hdiff = hneg ? 7'(r6 - b6) : 7'(b6 - r6);
            hbase = 9'd120;
        end
        else
        begin
            hneg  = r6 < g6;
            hdiff = hneg ? 7'(g6 - r6) : 7'(r6 - g6);
            hbase = 9'd240;
        end
        hnum = 13'(hdiff * 7'd60);
    end

    // Sobel
    logic [CW-1:0] w_use;
    logic [RW-1:0] h_use;
    logic [AW-1:0] ci;
    logic signed [10:0] gx, gy;
    logic [10:0] agx, agy;
    logic [11:0] mag;
    logic [6:0]  edge_v;
    always_comb
    begin
        if (width_reg == 9'd0) w_use = CW'(1);
        else if (32'(width_reg) > MAX_WIDTH) w_use = CW'(MAX_WIDTH);
        else w_use = CW'(width_reg);
        if (height_reg == 9'd0) h_use = RW'(1);
        else if (32'(height_reg) > MAX_HEIGHT) h_use = RW'(MAX_HEIGHT);
        else h_use = RW'(height_reg);
        ci = col_reg[AW-1:0];
        gx = 11'(signed'({4'b0, older_rd_reg})) + 11'(signed'({4'b0, lm}))
           - 11'(signed'({4'b0, win_reg[1]})) - 11'(signed'({4'b0, win_reg[5]}))
           + 11'(signed'({3'b0, prev_rd_reg, 1'b0}))
           - 11'(signed'({3'b0, win_reg[3], 1'b0}));
        gy = 11'(signed'({4'b0, win_reg[5]})) + 11'(signed'({4'b0, lm}))
           - 11'(signed'({4'b0, win_reg[1]})) - 11'(signed'({4'b0, older_rd_reg}))
           + 11'(signed'({3'b0, win_reg[4], 1'b0}))
           - 11'(signed'({3'b0, win_reg[0], 1'b0}));
        agx = gx[10] ? 11'(-gx) : 11'(gx);
        agy = gy[10] ? 11'(-gy) : 11'(gy);
        mag = {1'b0, agx} + {1'b0, agy};
        edge_v = (mag > 12'd127) ? rpas_pkg::EdgeSat : mag[6:0];
        if (edge_v < floor_reg) edge_v = 7'd0;
        if (!(col_reg > CW'(1) && row_reg > RW'(1))) edge_v = 7'd0;
    end

    logic [24:0] sum_add;
    logic        lend, fend;
    assign sum_add = {1'b0, sum_reg} + 25'(lm);
    assign lend = col_reg >= w_use - CW'(1);
    assign fend = lend && (row_reg >= h_use - RW'(1));

    rpas_pkg::div_req_t dreq;
    rpas_pkg::div_rsp_t drsp;
    rpas_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [23:0] sum_sat;
    assign sum_sat = sum_add[24] ? rpas_pkg::SumMax : sum_add[23:0];

    logic [16:0] div_use;
    assign div_use = (divisor_reg == 17'd0) ? 17'd1 : divisor_reg;

    logic hue_go;
    assign hue_go = !(dl < hmin_reg || dl == 6'd0);

    // hue quotient first; the frame mean starts from calc when there is no hue
    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = {11'b0, hnum};
        dreq.divisor  = {11'b0, dl};
        if (state_reg == S_CALC && hue_go)
            dreq.start = 1'b1;
        else if (state_reg == S_CALC && fend)
        begin
            dreq.start    = 1'b1;
            dreq.dividend = sum_sat;
            dreq.divisor  = div_use;
        end
        else if (state_reg == S_HDIV && drsp.done && fend_reg)
        begin
            dreq.start    = 1'b1;
            dreq.dividend = sum_reg;
            dreq.divisor  = div_use;
        end
    end

    logic [8:0] hq;
    assign hq = 9'(drsp.quotient);

    function automatic logic [8:0] hdiv_unused(input logic [5:0] d, input logic [5:0] m);
        return (d < m) ? rpas_pkg::NoHue : 9'd0;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            width_reg   <= 9'd160;
            height_reg  <= 9'd120;
            divisor_reg <= 17'd19200;
            hmin_reg    <= 6'd6;
            floor_reg   <= 7'd60;
            col_reg     <= '0;
            row_reg     <= '0;
            sum_reg     <= '0;
            hue_reg     <= '0;
            fend_reg    <= 1'b0;
            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rpas_pkg::CfgWidth:   width_reg   <= cfg_data[8:0];
                    rpas_pkg::CfgHeight:  height_reg  <= cfg_data[8:0];
                    rpas_pkg::CfgDivisor: divisor_reg <= cfg_data;
                    rpas_pkg::CfgHueMin:  hmin_reg    <= cfg_data[5:0];
                    rpas_pkg::CfgFloor:   floor_reg   <= cfg_data[6:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        state_reg <= S_READ;
                        if (frame_start)
                        begin
                            col_reg <= '0;
                            row_reg <= '0;
                            sum_reg <= '0;
                        end
                    end
                S_READ: state_reg <= S_CALC;
                S_CALC:
                begin
                    win_reg[1] <= win_reg[0];
                    win_reg[0] <= older_rd_reg;
                    win_reg[3] <= win_reg[2];
                    win_reg[2] <= prev_rd_reg;
                    win_reg[5] <= win_reg[4];
                    win_reg[4] <= lm;
                    // the divider has already taken the sum when the mean starts here
                    if (fend && !hue_go)
                        sum_reg <= '0;
                    else
                        sum_reg <= sum_sat;
                    fend_reg   <= fend;
                    if (fend)
                    begin
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    else if (lend)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + RW'(1);
                    end
                    else
                        col_reg <= col_reg + CW'(1);
                    if (hue_go) state_reg <= S_HDIV;
                    else if (fend)
                    begin
                        state_reg <= S_MDIV;
                        hue_reg   <= hdiv_unused(dl, hmin_reg);
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                        hue_reg   <= hdiv_unused(dl, hmin_reg);
                    end
                end
                S_HDIV:
                    if (drsp.done)
                    begin
                        hue_reg <= hneg_reg ? ((hbase_reg < hq) ?
                                   9'(hbase_reg + 9'd360 - hq) : 9'(hbase_reg - hq))
                                   : 9'(hbase_reg + hq);
                        state_reg <= fend_reg ? S_MDIV : S_OUT;
                        if (fend_reg)
                            sum_reg <= '0;
                    end
                S_MDIV:
                    if (drsp.done) state_reg <= S_OUT;
                S_OUT:
                    if (!out_stall) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            px_reg <= pixel_word;
        if (state_reg == S_READ)
        begin
            older_rd_reg <= older_mem[ci];
            prev_rd_reg  <= prev_mem[ci];
        end
        if (state_reg == S_CALC)
        begin
            older_mem[ci] <= prev_rd_reg;
            prev_mem[ci]  <= lm;
            luma_reg  <= lm;
            sat_reg   <= dl;
            edge_reg  <= edge_v;
            ocol_reg  <= 8'(col_reg);
            orow_reg  <= 8'(row_reg);
            hneg_reg  <= hneg;
            hbase_reg <= hbase;
            mean_reg  <= '0;
        end
        if (state_reg == S_MDIV && drsp.done)
            mean_reg <= (drsp.quotient > 24'd127) ? 7'd127 : drsp.quotient[6:0];
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = (state_reg == S_OUT);
    assign luma           = luma_reg;
    assign hue_deg        = hue_reg;
    assign saturation     = sat_reg;
    assign edge_strength  = edge_reg;
    assign attribute_word = {edge_reg, sat_reg, hue_reg, 1'b0, luma_reg};
    assign column         = ocol_reg;
    assign line           = orow_reg;
    assign frame_end      = fend_reg;
    assign mean_luma      = mean_reg;

    a_out_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input open while result pending");
    a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_end) |-> (mean_luma == 7'd0)) else $error("stray mean");
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hue_deg < 9'd360 || hue_deg == rpas_pkg::NoHue))
        else $error("hue out of range");

endmodule

FILE: tb/rpas_checker.sv
module rpas_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] pixel_word,
    input  logic        frame_start,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [6:0]  luma,
    input  logic [8:0]  hue_deg,
    input  logic [5:0]  saturation,
    input  logic [6:0]  edge_strength,
    input  logic [29:0] attribute_word,
    input  logic [7:0]  column,
    input  logic [7:0]  line,
    input  logic        frame_end,
    input  logic [6:0]  mean_luma,
    output int          fail_count,
    output int          pending,
    output int          pixels_checked,
    output int          frames_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0]  luma;
        logic [8:0]  hue;
        logic [5:0]  sat;
        logic [6:0]  edge_mag;
        logic [29:0] attr;
        logic [7:0]  col;
        logic [7:0]  row;
        logic        last;
        logic [6:0]  mean;
    } pixel_attr_t;

    pixel_attr_t attr_queue[$];

    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [16:0] divisor_reg;
    logic [5:0]  hue_min_reg;
    logic [6:0]  floor_reg;

    logic [6:0]  older_row[rpas_pkg::MaxWidthDef];
    logic [6:0]  prev_row[rpas_pkg::MaxWidthDef];
    logic [6:0]  win[6];
    int          col_cnt;
    int          row_cnt;
    int          sum_acc;

    function automatic int abs_int(input int v);
        return v < 0 ? -v : v;
    endfunction

    task automatic predict_pixel(input logic [15:0] raw, input logic start,
                                 output pixel_attr_t res);
        logic [15:0] px;
        int r5, g6, b5, r6, b6, mx, mn, delta, y, hv, edge_v, c, r, w, h, ci;
        int l1, l2, l3, l4, l5, l7, l8, gx, gy, div_v, mean_v;
        logic at_line_end, at_frame_end;
        begin
            w = (width_reg == 0) ? 1
                : (width_reg > rpas_pkg::MaxWidthDef ? rpas_pkg::MaxWidthDef : width_reg);
            h = (height_reg == 0) ? 1
                : (height_reg > rpas_pkg::MaxHeightDef ? rpas_pkg::MaxHeightDef
                                                       : height_reg);
            if (start)
            begin
                col_cnt = 0;
                row_cnt = 0;
                sum_acc = 0;
            end
            c = col_cnt;
            r = row_cnt;
            px = {raw[7:0], raw[15:8]};
            r5 = px[15:11];
            g6 = px[10:5];
            b5 = px[4:0];
            y = ((r5 << 2) + (g6 << 2) + (b5 << 1) + g6) >> 2;
            r6 = r5 * 2;
            b6 = b5 * 2;
            mx = r6; if (g6 > mx) mx = g6; if (b6 > mx) mx = b6;
            mn = r6; if (g6 < mn) mn = g6; if (b6 < mn) mn = b6;
            delta = mx - mn;
            if (delta < hue_min_reg)
                hv = rpas_pkg::NoHue;
            else if (delta == 0)
                hv = 0;
            else
            begin
                // signed division truncates toward zero
                if (r6 == mx)
                    hv = (60 * (g6 - b6)) / delta;
                else if (g6 == mx)
                    hv = 120 + (60 * (b6 - r6)) / delta;
                else
                    hv = 240 + (60 * (r6 - g6)) / delta;
                if (hv < 0)
                    hv += 360;
            end

            ci = c % rpas_pkg::MaxWidthDef;
            l1 = win[1]; l2 = older_row[ci];
            l3 = win[3]; l4 = prev_row[ci];
            l5 = win[5];
            l7 = win[0]; l8 = win[4];
            if (c > 1 && r > 1)
            begin
                gx = l2 + y - l1 - l5 + 2 * (l4 - l3);
                gy = l5 + y - l1 - l2 + 2 * (l8 - l7);
                edge_v = abs_int(gx) + abs_int(gy);
                if (edge_v > rpas_pkg::EdgeSat)
                    edge_v = rpas_pkg::EdgeSat;
                if (edge_v < floor_reg)
                    edge_v = 0;
            end
            else
                edge_v = 0;
            win[1] = win[0]; win[0] = l2[6:0];
            win[3] = win[2]; win[2] = l4[6:0];
            win[5] = win[4]; win[4] = y[6:0];
            older_row[ci] = l4[6:0];
            prev_row[ci] = y[6:0];

            sum_acc += y;
            if (sum_acc > rpas_pkg::SumMax)
                sum_acc = rpas_pkg::SumMax;

            mean_v = 0;
            at_line_end = c >= w - 1;
            at_frame_end = at_line_end && r >= h - 1;
            if (at_frame_end)
            begin
                div_v = (divisor_reg == 0) ? 1 : divisor_reg;
                mean_v = sum_acc / div_v;
                if (mean_v > 127)
                    mean_v = 127;
                sum_acc = 0;
                col_cnt = 0;
                row_cnt = 0;
            end
            else if (at_line_end)
            begin
                col_cnt = 0;
                row_cnt = r + 1;
            end
            else
                col_cnt = c + 1;

            res.luma = y[6:0];
            res.hue = hv[8:0];
            res.sat = delta[5:0];
            res.edge_mag = edge_v[6:0];
            res.attr = 30'(y | (hv << 8) | (delta << 17) | (edge_v << 23));
            res.col = c[7:0];
            res.row = r[7:0];
            res.last = at_frame_end;
            res.mean = mean_v[6:0];
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_attr_t exp_res;
        pixel_attr_t got;
        if (!rst_n)
        begin
            width_reg = 9'd160;
            height_reg = 9'd120;
            divisor_reg = 17'd19200;
            hue_min_reg = 6'd6;
            floor_reg = 7'd60;
            foreach (win[i]) win[i] = '0;
            foreach (older_row[i]) older_row[i] = '0;
            foreach (prev_row[i]) prev_row[i] = '0;
            col_cnt = 0;
            row_cnt = 0;
            sum_acc = 0;
            attr_queue.delete();
            fail_count = 0;
            pending = 0;
            pixels_checked = 0;
            frames_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rpas_pkg::CfgWidth:   width_reg = cfg_data[8:0];
                    rpas_pkg::CfgHeight:  height_reg = cfg_data[8:0];
                    rpas_pkg::CfgDivisor: divisor_reg = cfg_data;
                    rpas_pkg::CfgHueMin:  hue_min_reg = cfg_data[5:0];
                    rpas_pkg::CfgFloor:   floor_reg = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                predict_pixel(pixel_word, frame_start, exp_res);
                attr_queue.push_back(exp_res);
            end
            if (out_valid && !out_stall)
            begin
                got = '{luma, hue_deg, saturation, edge_strength, attribute_word,
                        column, line, frame_end, mean_luma};
                if (attr_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with nothing outstanding: %p", $time, got);
                end
                else
                begin
                    exp_res = attr_queue.pop_front();
                    pixels_checked++;
                    if (exp_res.last)
                        frames_seen++;
                    if (got !== exp_res)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch\n  expected %p\n  actual   %p",
                                     $time, exp_res, got);
                    end
                end
            end
            pending = attr_queue.size();
        end
    end

endmodule

FILE: tb/tb_rgb565_pixel_attribute_sobel_unit.sv
module tb_rgb565_pixel_attribute_sobel_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] pixel_word;
    logic        frame_start;
    logic        out_valid;
    logic        out_stall;
    logic [6:0]  luma;
    logic [8:0]  hue_deg;
    logic [5:0]  saturation;
    logic [6:0]  edge_strength;
    logic [29:0] attribute_word;
    logic [7:0]  column;
    logic [7:0]  line;
    logic        frame_end;
    logic [6:0]  mean_luma;

    int fail_count, pending, pixels_checked, frames_seen;
    int settings_used;
    bit no_idle;
    bit hold_req;

    rgb565_pixel_attribute_sobel_unit u_top (.*);

    rpas_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("rgb565_pixel_attribute_sobel_unit test failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_cnt;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                for (hold_cnt = 0; hold_cnt < 300; hold_cnt++)
                    @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= !no_idle && ($urandom_range(99) < 19);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[16:0];
        @(posedge clk);
    endtask

    task automatic set_config(input int w, input int h, input int div,
                              input int hmin, input int flr);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        write_reg(rpas_pkg::CfgWidth, w);
        write_reg(rpas_pkg::CfgHeight, h);
        write_reg(rpas_pkg::CfgDivisor, div);
        write_reg(rpas_pkg::CfgHueMin, hmin);
        write_reg(rpas_pkg::CfgFloor, flr);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_pixel(input logic [15:0] word, input logic start);
        if (!no_idle && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_word <= word;
        frame_start <= start;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic logic [15:0] pick_pixel(input logic [15:0] base);
        // mostly random, sometimes a small step from the last pixel to keep
        // gradients below saturation
        if ($urandom_range(99) < 60)
            return 16'($urandom);
        return base ^ 16'(1 << $urandom_range(15));
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(9))
            0: return 0;
            1: return 1;
            2: return 2;
            3: return 511;
            4: return 256;
            default: return $urandom_range(3, 12);
        endcase
    endfunction

    initial
    begin
        logic [15:0] directed[20];
        logic [15:0] last_px;
        int n, div_v;

        directed = '{16'h0000, 16'hFFFF, 16'h00F8, 16'hE007,
            16'h1F00, 16'hE0FF, 16'hFF07, 16'h1FF8, 16'h1084, 16'h0800,
            16'h0001, 16'h2000, 16'h0100, 16'h00F8, 16'h1F00, 16'hFFFF,
            16'h0000, 16'h5555, 16'hAAAA, 16'h00F0};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel_word = '0;
        frame_start = 1'b0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        settings_used = 0;
        last_px = 16'h0000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-width frame first so every line store entry holds real data
        set_config(256, 3, 768, 0, 0);
        for (int i = 0; i < 768; i++)
        begin
            last_px = pick_pixel(last_px);
            send_pixel(last_px, i == 0);
        end

        // primaries, grey, extremes; divisor zero; restart mid-frame
        set_config(5, 4, 0, 0, 0);
        for (int i = 0; i < 20; i++)
            send_pixel(directed[i], i == 0 || i == 12);
        set_config(5, 3, 1, 63, 127);
        for (int i = 0; i < 15; i++)
            send_pixel(directed[19 - i], 1'b0);

        for (int p = 0; p < 12; p++)
        begin
            case (p % 4)
                0: div_v = 0;
                1: div_v = 17'h10000;
                2: div_v = 1;
                default: div_v = $urandom_range(1, 200);
            endcase
            // odd phases carry on the previous frame without a frame start
            set_config(pick_dim(), pick_dim(), div_v, $urandom_range(63),
                       $urandom_range(127));
            no_idle = (p == 5);
            if (p == 2)
                hold_req = 1'b1;
            n = $urandom_range(70, 110);
            for (int i = 0; i < n; i++)
            begin
                last_px = pick_pixel(last_px);
                send_pixel(last_px, (i == 0 && p[0] == 1'b0) || $urandom_range(99) < 2);
            end
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Checked %0d pixel requests across %0d frames under %0d settings,",
                 pixels_checked, frames_seen, settings_used);
        $display("with random stalls on both sides and one long output hold-off.");
        if (fail_count == 0)
            $display("rgb565_pixel_attribute_sobel_unit test passed");
        else
            $display("rgb565_pixel_attribute_sobel_unit test failed");
        $finish;
    end

endmodule
